>>> rtl/core/rsk_pkg.sv
package rsk_pkg;

  // Capacity and derived widths.
  localparam int MAX_KEYS    = 1024;
  localparam int KEY_AW      = $clog2(MAX_KEYS);
  localparam int CNT_W       = $clog2(MAX_KEYS + 1);
  localparam int DIGIT_BITS  = 8;
  localparam int DIGIT_COUNT = 1 << DIGIT_BITS;
  localparam int IDX_W       = (CNT_W > DIGIT_BITS + 1) ? CNT_W : DIGIT_BITS + 1;
  localparam int KEY_W       = 32;
  localparam int PASS_COUNT  = KEY_W / DIGIT_BITS;
  localparam int PASS_W      = $clog2(PASS_COUNT);

  // Key format codes.
  localparam logic [1:0] FMT_UNSIGNED = 2'd0;
  localparam logic [1:0] FMT_SIGNED   = 2'd1;
  localparam logic [1:0] FMT_FLOAT    = 2'd2;

  // Item actions.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [1:0] STATUS_DROPPED = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CLR,
    ST_CNT_RD,
    ST_CNT_DIG,
    ST_CNT_WR,
    ST_PRE_RD,
    ST_PRE_WR,
    ST_SC_RD,
    ST_SC_DIG,
    ST_SC_WR
  } state_t;

  // Maps a raw key to its ordering pattern and picks the digit of this pass.
  function automatic logic [DIGIT_BITS-1:0] key_digit(input logic [KEY_W-1:0] key,
                                                      input logic [1:0] fmt,
                                                      input logic [PASS_W-1:0] pass);
    logic [KEY_W-1:0] pat;
    case (fmt)
      FMT_SIGNED: pat = key ^ {1'b1, {(KEY_W-1){1'b0}}};
      FMT_FLOAT:  pat = key[KEY_W-1] ? ~key : (key ^ {1'b1, {(KEY_W-1){1'b0}}});
      default:    pat = key;
    endcase
    return pat[{pass, {$clog2(DIGIT_BITS){1'b0}}} +: DIGIT_BITS];
  endfunction

endpackage

>>> rtl/core/rsk_ram.sv
module rsk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/radix_sort_32bit_keys.sv
// Loads are accepted while idle. An empty fetch result is registered in the
// cycle after the item is accepted; a fetch that reads a key passes through
// the fetch state, which registers the stored key to the output. After the
// final key, each of four sort passes clears and prefixes the 256-entry offset
// memory, and per key the count and scatter loops read key, offset, then write.
// Synchronous active-low reset empties the set and sets the format to unsigned.
module radix_sort_32bit_keys (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [1:0]                 cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic [31:0]                in_key_in,
  input  logic                       in_final_key,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [31:0]                out_sorted_key,
  output logic                       out_end_of_set,
  output logic [1:0]                 out_status
);
  import rsk_pkg::*;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       key_count_r, key_count_nxt;
  logic [CNT_W-1:0]       read_index_r, read_index_nxt;
  logic                   overflow_r, overflow_nxt;
  logic                   sorted_r, sorted_nxt;
  logic [1:0]             fmt_r;
  logic [PASS_W-1:0]      pass_r, pass_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]       sum_r, sum_nxt;
  logic [DIGIT_BITS-1:0]  digit_r, digit_nxt;
  logic [KEY_W-1:0]       key_hold_r, key_hold_nxt;
  logic                   fetch_eos_r, fetch_eos_nxt;
  logic [1:0]             fetch_status_r, fetch_status_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]       out_key_r, out_key_nxt;
  logic                   out_eos_r, out_eos_nxt;
  logic [1:0]             out_status_r, out_status_nxt;

  // Memory ports.
  logic                   a_we, b_we, off_we;
  logic [KEY_AW-1:0]      a_waddr, a_raddr, b_waddr, b_raddr;
  logic [KEY_W-1:0]       a_wdata, b_wdata, a_rdata, b_rdata;
  logic [DIGIT_BITS-1:0]  off_waddr, off_raddr;
  logic [CNT_W-1:0]       off_wdata, off_rdata;

  logic                   accept, out_free, fetch_hit;
  logic [KEY_W-1:0]       src_rdata;
  logic [DIGIT_BITS-1:0]  src_digit;
  logic [CNT_W-1:0]       load_count;

  rsk_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_store_a (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  rsk_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_store_b (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  rsk_ram #(.WIDTH(CNT_W), .DEPTH(DIGIT_COUNT)) u_offsets (
    .clk(clk), .we(off_we), .waddr(off_waddr), .wdata(off_wdata),
    .raddr(off_raddr), .rdata(off_rdata)
  );

  // Handshake and shared terms.
  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = (state_r != ST_IDLE) || ((in_action == ACT_FETCH) && !out_free);
  assign accept     = in_valid && !in_stall;
  assign fetch_hit  = sorted_r && (read_index_r < key_count_r);
  assign load_count = sorted_r ? '0 : key_count_r;
  assign src_rdata  = pass_r[0] ? b_rdata : a_rdata;
  assign src_digit  = key_digit(src_rdata, fmt_r, pass_r);

  assign out_valid      = out_valid_r;
  assign out_sorted_key = out_key_r;
  assign out_end_of_set = out_eos_r;
  assign out_status     = out_status_r;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      key_count_r  <= '0;
      read_index_r <= '0;
      overflow_r   <= 1'b0;
      sorted_r     <= 1'b0;
      fmt_r        <= FMT_UNSIGNED;
      pass_r       <= '0;
      idx_r        <= '0;
      sum_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      key_count_r  <= key_count_nxt;
      read_index_r <= read_index_nxt;
      overflow_r   <= overflow_nxt;
      sorted_r     <= sorted_nxt;
      pass_r       <= pass_nxt;
      idx_r        <= idx_nxt;
      sum_r        <= sum_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        fmt_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    digit_r        <= digit_nxt;
    key_hold_r     <= key_hold_nxt;
    fetch_eos_r    <= fetch_eos_nxt;
    fetch_status_r <= fetch_status_nxt;
    out_key_r      <= out_key_nxt;
    out_eos_r      <= out_eos_nxt;
    out_status_r   <= out_status_nxt;
  end

  // Sequencer: load, fetch and the four sort passes.
  always_comb begin
    state_nxt        = state_r;
    key_count_nxt    = key_count_r;
    read_index_nxt   = read_index_r;
    overflow_nxt     = overflow_r;
    sorted_nxt       = sorted_r;
    pass_nxt         = pass_r;
    idx_nxt          = idx_r;
    sum_nxt          = sum_r;
    digit_nxt        = digit_r;
    key_hold_nxt     = key_hold_r;
    fetch_eos_nxt    = fetch_eos_r;
    fetch_status_nxt = fetch_status_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_key_nxt      = out_key_r;
    out_eos_nxt      = out_eos_r;
    out_status_nxt   = out_status_r;

    a_we      = 1'b0;
    a_waddr   = load_count[KEY_AW-1:0];
    a_wdata   = in_key_in;
    a_raddr   = pass_r[0] ? read_index_r[KEY_AW-1:0] : idx_r[KEY_AW-1:0];
    b_we      = 1'b0;
    b_waddr   = off_rdata[KEY_AW-1:0];
    b_wdata   = key_hold_r;
    b_raddr   = idx_r[KEY_AW-1:0];
    off_we    = 1'b0;
    off_waddr = digit_r;
    off_wdata = off_rdata + CNT_W'(1);
    off_raddr = src_digit;

    unique case (state_r)
      ST_IDLE: begin
        a_raddr = read_index_r[KEY_AW-1:0];
        if (accept && (in_action == ACT_LOAD)) begin
          if (sorted_r) begin
            read_index_nxt = '0;
            overflow_nxt   = 1'b0;
            sorted_nxt     = 1'b0;
          end
          if (load_count < CNT_W'(MAX_KEYS)) begin
            a_we          = 1'b1;
            key_count_nxt = load_count + CNT_W'(1);
          end else begin
            key_count_nxt = load_count;
            overflow_nxt  = 1'b1;
          end
          if (in_final_key) begin
            state_nxt = ST_CLR;
            pass_nxt  = '0;
            idx_nxt   = '0;
          end
        end else if (accept) begin
          if (fetch_hit) begin
            fetch_eos_nxt    = (read_index_r + CNT_W'(1)) == key_count_r;
            fetch_status_nxt = overflow_r ? STATUS_DROPPED : STATUS_OK;
            read_index_nxt   = read_index_r + CNT_W'(1);
            state_nxt        = ST_FETCH;
          end else begin
            out_valid_nxt  = 1'b1;
            out_key_nxt    = '0;
            out_eos_nxt    = 1'b0;
            out_status_nxt = STATUS_EMPTY;
          end
        end
      end
      ST_FETCH: begin
        out_valid_nxt  = 1'b1;
        out_key_nxt    = a_rdata;
        out_eos_nxt    = fetch_eos_r;
        out_status_nxt = fetch_status_r;
        state_nxt      = ST_IDLE;
      end
      // Clear the offset memory.
      ST_CLR: begin
        off_we    = 1'b1;
        off_waddr = idx_r[DIGIT_BITS-1:0];
        off_wdata = '0;
        sum_nxt   = '0;
        if (idx_r == IDX_W'(DIGIT_COUNT - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_CNT_RD;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      // Count digits: read key, read count, write count plus one.
      ST_CNT_RD: begin
        if (idx_r == IDX_W'(key_count_r)) begin
          idx_nxt   = '0;
          state_nxt = ST_PRE_RD;
        end else begin
          state_nxt = ST_CNT_DIG;
        end
      end
      ST_CNT_DIG: begin
        digit_nxt = src_digit;
        state_nxt = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        off_we    = 1'b1;
        idx_nxt   = idx_r + IDX_W'(1);
        state_nxt = ST_CNT_RD;
      end
      // Exclusive prefix sum over the counts.
      ST_PRE_RD: begin
        off_raddr = idx_r[DIGIT_BITS-1:0];
        state_nxt = ST_PRE_WR;
      end
      ST_PRE_WR: begin
        off_we    = 1'b1;
        off_waddr = idx_r[DIGIT_BITS-1:0];
        off_wdata = sum_r;
        sum_nxt   = sum_r + off_rdata;
        if (idx_r == IDX_W'(DIGIT_COUNT - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_SC_RD;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_PRE_RD;
        end
      end
      // Scatter keys to the other store at their digit's running offset.
      ST_SC_RD: begin
        if (idx_r == IDX_W'(key_count_r)) begin
          idx_nxt = '0;
          if (pass_r == PASS_W'(PASS_COUNT - 1)) begin
            read_index_nxt = '0;
            sorted_nxt     = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            pass_nxt  = pass_r + PASS_W'(1);
            state_nxt = ST_CLR;
          end
        end else begin
          state_nxt = ST_SC_DIG;
        end
      end
      ST_SC_DIG: begin
        digit_nxt    = src_digit;
        key_hold_nxt = src_rdata;
        state_nxt    = ST_SC_WR;
      end
      ST_SC_WR: begin
        off_we  = 1'b1;
        a_waddr = off_rdata[KEY_AW-1:0];
        a_wdata = key_hold_r;
        if (pass_r[0]) begin
          a_we = 1'b1;
        end else begin
          b_we = 1'b1;
        end
        idx_nxt   = idx_r + IDX_W'(1);
        state_nxt = ST_SC_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/rsk_checker.sv
module rsk_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_action,
  input logic        in_final_key,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_sorted_key,
  input logic        out_end_of_set,
  input logic [1:0]  out_status
);
  import rsk_pkg::*;

  // A result held back by the receiver stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // An empty fetch carries a zero key and no end mark.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_EMPTY) |-> (out_sorted_key == '0) && !out_end_of_set)
    else $error("empty result carries data");

  // The final key of a set starts the sort, which holds off new items.
  a_sort_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_action == ACT_LOAD) && in_final_key |=> in_stall)
    else $error("item taken while sorting");

  // No result is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result after reset");

endmodule

bind radix_sort_32bit_keys rsk_checker u_rsk_checker (.*);
